// ----- sv/tdoa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA localizer package
// Shared widths, status and register codes, and the job record that passes
// from the front part to the divider back part.
// ----------------------------------------------------------------------------
`default_nettype none

package tdoa_pkg;

  localparam int unsigned FIELD_W  = 20;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CIDX_W   = 2;

  localparam int unsigned DIFF_W   = 21;
  localparam int unsigned SQ_W     = 42;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned QS_W     = 44;
  localparam int unsigned AZ_W     = 46;
  localparam int unsigned PP_W     = 48;
  localparam int unsigned NUM_W    = 70;
  localparam int unsigned MAG_W    = 69;
  localparam int unsigned DEN_W    = 46;
  localparam int unsigned GMAG_W   = 22;
  localparam int unsigned LANES    = 3;

  localparam int unsigned DEF_FRACTION_BITS = 8;
  localparam int unsigned RESET_UNITS       = 10;

  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_ENERGY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SINGULAR    = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_HALF_SIDE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT    = 2'd1;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    logic [DEN_W-1:0]            den_xy;
    logic [DEN_W-1:0]            den_z;
    logic [STAT_W-1:0]           status;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/tdoa_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA localizer channels
// Range request, position result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdoa_in_if;
  import tdoa_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] range_rx0;
  logic [FIELD_W-1:0] range_rx1;
  logic [FIELD_W-1:0] range_rx2;
  logic [FIELD_W-1:0] range_rx3;
  logic [FIELD_W-1:0] range_ref;
  modport source (output valid, range_rx0, range_rx1, range_rx2, range_rx3, range_ref,
                  input ready);
  modport sink   (input valid, range_rx0, range_rx1, range_rx2, range_rx3, range_ref,
                  output ready);
endinterface

interface tdoa_out_if;
  import tdoa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [STAT_W-1:0]        status;
  modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

interface tdoa_cfg_if;
  import tdoa_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [FIELD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/tdoa_source_localizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA source localizer
// Least-squares source position from four receiver ranges and a reference.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  rng_i    in   valid/ready            range_rx0..range_rx3, range_ref
//  pos_o    out  valid/ready            pos_x, pos_y, pos_z, status
//  cfg_i    in   valid/ready (ready=1)  index, data
//
// The front pipeline takes a request every cycle unless its last stage is held by a full queue.
// The divider back part takes a new request only once it has finished the last one, which sets the sustained rate.
// A two-entry queue and the result register let either side stall independently.
// Reset returns both geometry registers to 10.0 and empties all stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoa_source_localizer #(
  parameter int unsigned FRACTION_BITS = tdoa_pkg::DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdoa_in_if.sink     rng_i,
  tdoa_cfg_if.sink    cfg_i,
  tdoa_out_if.source  pos_o
);
  import tdoa_pkg::*;

  localparam logic [FIELD_W-1:0] CFG_RESET = FIELD_W'(RESET_UNITS << FRACTION_BITS);

  logic [FIELD_W-1:0] half_side_q, height_q;
  job_t               fjob, bjob;
  logic               fvalid, fready, bvalid, bready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_side_q <= CFG_RESET;
      height_q    <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_HALF_SIDE: half_side_q <= cfg_i.data;
        CFG_HEIGHT:    height_q    <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  tdoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rng_i       (rng_i),
    .half_side_i (half_side_q),
    .height_i    (height_q),
    .job_o       (fjob),
    .job_valid_o (fvalid),
    .job_ready_i (fready)
  );

  tdoa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_job_i   (fjob),
    .wr_valid_i (fvalid),
    .wr_ready_o (fready),
    .rd_job_o   (bjob),
    .rd_valid_o (bvalid),
    .rd_ready_i (bready)
  );

  tdoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (bjob),
    .job_valid_i (bvalid),
    .job_ready_o (bready),
    .pos_o       (pos_o)
  );

endmodule

`default_nettype wire

// ----- sv/tdoa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA localizer front part
// Seven-stage pipeline from ranges to numerator magnitudes, divisors and status.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoa_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tdoa_in_if.sink                 rng_i,
  input  logic [tdoa_pkg::FIELD_W-1:0] half_side_i,
  input  logic [tdoa_pkg::FIELD_W-1:0] height_i,
  output tdoa_pkg::job_t          job_o,
  output logic                    job_valid_o,
  input  logic                    job_ready_i
);
  import tdoa_pkg::*;

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] vld_q;
  logic            en;

  logic signed [DIFF_W-1:0] d1_d [4];
  logic signed [DIFF_W-1:0] d1_q [4];

  logic signed [SQ_W-1:0]  sq2_d [4];
  logic signed [SQ_W-1:0]  sq2_q [4];
  logic signed [SUM_W-1:0] e2_d, f2_d, t2_d, g2_d, e2_q, f2_q, t2_q, g2_q;
  logic [2*FIELD_W-1:0]    ss2_d, hh2_d, ss2_q, hh2_q;

  logic signed [QS_W-1:0]  qe3_d, qf3_d, qg3_d, sum3_d, qe3_q, qf3_q, qg3_q;
  logic signed [AZ_W-1:0]  az3_d, az3_q;
  logic signed [SUM_W-1:0] e3_q, f3_q, t3_q, g3_q;
  logic [2*FIELD_W+1:0]    kk3;
  logic [GMAG_W-1:0]       gmag3;
  logic [FIELD_W+GMAG_W-1:0] sg3, hg3;
  logic [DEN_W-1:0]        dxy3_d, dz3_d, dxy3_q, dz3_q;
  logic [STAT_W-1:0]       st3_d, st3_q;
  logic                    gn3_q;

  logic signed [PP_W-1:0]  pl4_d [6];
  logic signed [PP_W-1:0]  ph4_d [6];
  logic signed [PP_W-1:0]  pl4_q [6];
  logic signed [PP_W-1:0]  ph4_q [6];
  logic [DEN_W-1:0]        dxy4_q, dz4_q;
  logic [STAT_W-1:0]       st4_q;
  logic                    gn4_q;

  logic signed [NUM_W-1:0] pf5_d [6];
  logic signed [NUM_W-1:0] pf5_q [6];
  logic [DEN_W-1:0]        dxy5_q, dz5_q;
  logic [STAT_W-1:0]       st5_q;
  logic                    gn5_q;

  logic signed [NUM_W-1:0] num6_d [LANES];
  logic signed [NUM_W-1:0] num6_q [LANES];
  logic [DEN_W-1:0]        dxy6_q, dz6_q;
  logic [STAT_W-1:0]       st6_q;
  logic                    gn6_q;

  logic [MAG_W-1:0]        mag7_d [LANES];
  logic [MAG_W-1:0]        mag7_q [LANES];
  logic [LANES-1:0]        neg7_d, neg7_q;
  logic [DEN_W-1:0]        dxy7_q, dz7_q;
  logic [STAT_W-1:0]       st7_q;

  assign en          = !vld_q[NSTG-1] || job_ready_i;
  assign rng_i.ready = en;
  assign job_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], rng_i.valid};
    end
  end

  always_comb begin
    d1_d[0] = $signed({1'b0, rng_i.range_rx0}) - $signed({1'b0, rng_i.range_ref});
    d1_d[1] = $signed({1'b0, rng_i.range_rx1}) - $signed({1'b0, rng_i.range_ref});
    d1_d[2] = $signed({1'b0, rng_i.range_rx2}) - $signed({1'b0, rng_i.range_ref});
    d1_d[3] = $signed({1'b0, rng_i.range_rx3}) - $signed({1'b0, rng_i.range_ref});
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq2_d[i] = SQ_W'(d1_q[i]) * SQ_W'(d1_q[i]);
    end
    e2_d  = SUM_W'(d1_q[0]) - SUM_W'(d1_q[1]) - SUM_W'(d1_q[2]) + SUM_W'(d1_q[3]);
    f2_d  = SUM_W'(d1_q[0]) + SUM_W'(d1_q[1]) - SUM_W'(d1_q[2]) - SUM_W'(d1_q[3]);
    t2_d  = SUM_W'(d1_q[0]) + SUM_W'(d1_q[1]) + SUM_W'(d1_q[2]) + SUM_W'(d1_q[3]);
    g2_d  = SUM_W'(d1_q[0]) - SUM_W'(d1_q[1]) + SUM_W'(d1_q[2]) - SUM_W'(d1_q[3]);
    ss2_d = half_side_i * half_side_i;
    hh2_d = height_i * height_i;
  end

  always_comb begin
    qe3_d  = QS_W'(sq2_q[0]) - QS_W'(sq2_q[1]) - QS_W'(sq2_q[2]) + QS_W'(sq2_q[3]);
    qf3_d  = QS_W'(sq2_q[0]) + QS_W'(sq2_q[1]) - QS_W'(sq2_q[2]) - QS_W'(sq2_q[3]);
    qg3_d  = QS_W'(sq2_q[0]) - QS_W'(sq2_q[1]) + QS_W'(sq2_q[2]) - QS_W'(sq2_q[3]);
    sum3_d = QS_W'(sq2_q[0]) + QS_W'(sq2_q[1]) + QS_W'(sq2_q[2]) + QS_W'(sq2_q[3]);
    kk3    = {1'b0, ss2_q, 1'b0} + {2'b00, hh2_q};
    az3_d  = $signed({2'b00, kk3, 2'b00}) - AZ_W'(sum3_d);
    gmag3  = GMAG_W'(g2_q[SUM_W-1] ? -g2_q : g2_q);
    sg3    = half_side_i * gmag3;
    hg3    = height_i * gmag3;
    dxy3_d = DEN_W'({sg3, 3'b000});
    dz3_d  = DEN_W'({hg3, 3'b000});
    if (sq2_q[0] == '0 && sq2_q[1] == '0 && sq2_q[2] == '0 && sq2_q[3] == '0) begin
      st3_d = STAT_ZERO_ENERGY;
    end else if (g2_q == '0 || half_side_i == '0 || height_i == '0) begin
      st3_d = STAT_SINGULAR;
    end else begin
      st3_d = STAT_OK;
    end
  end

  always_comb begin
    pl4_d[0] = PP_W'(e3_q) * PP_W'($signed({1'b0, qg3_q[21:0]}));
    ph4_d[0] = PP_W'(e3_q) * PP_W'($signed(qg3_q[QS_W-1:22]));
    pl4_d[1] = PP_W'(g3_q) * PP_W'($signed({1'b0, qe3_q[21:0]}));
    ph4_d[1] = PP_W'(g3_q) * PP_W'($signed(qe3_q[QS_W-1:22]));
    pl4_d[2] = PP_W'(f3_q) * PP_W'($signed({1'b0, qg3_q[21:0]}));
    ph4_d[2] = PP_W'(f3_q) * PP_W'($signed(qg3_q[QS_W-1:22]));
    pl4_d[3] = PP_W'(g3_q) * PP_W'($signed({1'b0, qf3_q[21:0]}));
    ph4_d[3] = PP_W'(g3_q) * PP_W'($signed(qf3_q[QS_W-1:22]));
    pl4_d[4] = PP_W'(t3_q) * PP_W'($signed({1'b0, qg3_q[21:0]}));
    ph4_d[4] = PP_W'(t3_q) * PP_W'($signed(qg3_q[QS_W-1:22]));
    pl4_d[5] = PP_W'(g3_q) * PP_W'($signed({1'b0, az3_q[22:0]}));
    ph4_d[5] = PP_W'(g3_q) * PP_W'($signed(az3_q[AZ_W-1:23]));
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      pf5_d[k] = (NUM_W'(ph4_q[k]) <<< 22) + NUM_W'(pl4_q[k]);
    end
    pf5_d[5] = (NUM_W'(ph4_q[5]) <<< 23) + NUM_W'(pl4_q[5]);
  end

  always_comb begin
    num6_d[0] = pf5_q[0] - pf5_q[1];
    num6_d[1] = pf5_q[2] - pf5_q[3];
    num6_d[2] = pf5_q[5] + pf5_q[4];
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag7_d[l] = MAG_W'(num6_q[l][NUM_W-1] ? -num6_q[l] : num6_q[l]);
      neg7_d[l] = num6_q[l][NUM_W-1] ^ gn6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= d1_d;
      sq2_q  <= sq2_d;
      e2_q   <= e2_d;
      f2_q   <= f2_d;
      t2_q   <= t2_d;
      g2_q   <= g2_d;
      ss2_q  <= ss2_d;
      hh2_q  <= hh2_d;
      qe3_q  <= qe3_d;
      qf3_q  <= qf3_d;
      qg3_q  <= qg3_d;
      az3_q  <= az3_d;
      e3_q   <= e2_q;
      f3_q   <= f2_q;
      t3_q   <= t2_q;
      g3_q   <= g2_q;
      gn3_q  <= g2_q[SUM_W-1];
      dxy3_q <= dxy3_d;
      dz3_q  <= dz3_d;
      st3_q  <= st3_d;
      pl4_q  <= pl4_d;
      ph4_q  <= ph4_d;
      dxy4_q <= dxy3_q;
      dz4_q  <= dz3_q;
      st4_q  <= st3_q;
      gn4_q  <= gn3_q;
      pf5_q  <= pf5_d;
      dxy5_q <= dxy4_q;
      dz5_q  <= dz4_q;
      st5_q  <= st4_q;
      gn5_q  <= gn4_q;
      num6_q <= num6_d;
      dxy6_q <= dxy5_q;
      dz6_q  <= dz5_q;
      st6_q  <= st5_q;
      gn6_q  <= gn5_q;
      mag7_q <= mag7_d;
      neg7_q <= neg7_d;
      dxy7_q <= dxy6_q;
      dz7_q  <= dz6_q;
      st7_q  <= st6_q;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      job_o.mag[l] = mag7_q[l];
    end
    job_o.neg    = neg7_q;
    job_o.den_xy = dxy7_q;
    job_o.den_z  = dz7_q;
    job_o.status = st7_q;
  end

endmodule

`default_nettype wire

// ----- sv/tdoa_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA localizer job queue
// Two-entry queue between the front pipeline and the divider back part.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tdoa_pkg::job_t wr_job_i,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  output tdoa_pkg::job_t rd_job_o,
  output logic           rd_valid_o,
  input  logic           rd_ready_i
);
  import tdoa_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_job_o   = slot_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= wr_job_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tdoa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA localizer back part
// Three-lane restoring divider, four quotient bits per cycle, with rounding,
// saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tdoa_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  tdoa_out_if.source     pos_o
);
  import tdoa_pkg::*;

  localparam int unsigned STEPS = 4;
  localparam int unsigned CNT_W = $clog2(POS_W / STEPS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(POS_W / STEPS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W-1:0]   rem_q [LANES];
  logic [POS_W-1:0]   nlo_q [LANES];
  logic [POS_W-1:0]   quo_q [LANES];
  logic [DEN_W-1:0]   den_q [LANES];
  logic [LANES-1:0]   sat_q, neg_q;
  logic [STAT_W-1:0]  stat_q;
  logic               out_valid_q;
  logic [POS_W-1:0]   res_q [LANES];
  logic [STAT_W-1:0]  ostat_q;

  logic [DEN_W-1:0]   rem_d [LANES];
  logic [POS_W-1:0]   nlo_d [LANES];
  logic [POS_W-1:0]   quo_d [LANES];
  logic [POS_W-1:0]   res_d [LANES];
  logic [DEN_W-1:0]   lden  [LANES];
  logic [LANES-1:0]   lsat;
  logic               out_free, take;

  assign out_free    = !out_valid_q || pos_o.ready;
  assign job_ready_o = (state_q == ST_IDLE) || (state_q == ST_DONE && out_free);
  assign take        = job_valid_i && job_ready_o;

  always_comb begin
    lden[0] = job_i.den_xy;
    lden[1] = job_i.den_xy;
    lden[2] = job_i.den_z;
    for (int l = 0; l < LANES; l++) begin
      lsat[l] = {{(DEN_W + POS_W - MAG_W){1'b0}}, job_i.mag[l]} >= {lden[l], {POS_W{1'b0}}};
    end
  end

  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] r;
    logic [POS_W-1:0] nl, qq;
    for (int l = 0; l < LANES; l++) begin
      r  = rem_q[l];
      nl = nlo_q[l];
      qq = quo_q[l];
      for (int s = 0; s < STEPS; s++) begin
        trial = {r, nl[POS_W-1]};
        if (trial >= {1'b0, den_q[l]}) begin
          trial = trial - {1'b0, den_q[l]};
          qq    = {qq[POS_W-2:0], 1'b1};
        end else begin
          qq    = {qq[POS_W-2:0], 1'b0};
        end
        r  = trial[DEN_W-1:0];
        nl = {nl[POS_W-2:0], 1'b0};
      end
      rem_d[l] = r;
      nlo_d[l] = nl;
      quo_d[l] = qq;
    end
  end

  always_comb begin
    logic [POS_W:0] qr;
    logic           up;
    for (int l = 0; l < LANES; l++) begin
      up = {rem_q[l], 1'b0} >= {1'b0, den_q[l]};
      qr = {1'b0, quo_q[l]} + (POS_W + 1)'(up);
      if (stat_q != STAT_OK) begin
        res_d[l] = '0;
      end else if (neg_q[l]) begin
        if (sat_q[l] || qr > {2'b01, {(POS_W - 1){1'b0}}}) begin
          res_d[l] = {1'b1, {(POS_W - 1){1'b0}}};
        end else begin
          res_d[l] = POS_W'(-qr);
        end
      end else begin
        if (sat_q[l] || qr > {2'b00, {(POS_W - 1){1'b1}}}) begin
          res_d[l] = {1'b0, {(POS_W - 1){1'b1}}};
        end else begin
          res_d[l] = qr[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_q <= rem_d;
          nlo_q <= nlo_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_CNT) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res_q   <= res_d;
            ostat_q <= stat_q;
            state_q <= take ? ST_RUN : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pos_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        cnt_q   <= '0;
        stat_q  <= job_i.status;
        neg_q   <= job_i.neg;
        sat_q   <= lsat;
        for (int l = 0; l < LANES; l++) begin
          rem_q[l] <= DEN_W'(job_i.mag[l][MAG_W-1:POS_W]);
          nlo_q[l] <= job_i.mag[l][POS_W-1:0];
          quo_q[l] <= '0;
          den_q[l] <= lden[l];
        end
      end
    end
  end

  assign pos_o.valid  = out_valid_q;
  assign pos_o.pos_x  = $signed(res_q[0]);
  assign pos_o.pos_y  = $signed(res_q[1]);
  assign pos_o.pos_z  = $signed(res_q[2]);
  assign pos_o.status = ostat_q;

endmodule

`default_nettype wire

// ----- tb/tdoa_source_localizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDOA source localizer testbench
// Drives range requests, geometry writes and a stalling result sink, predicts
// every position fix in wide integer arithmetic and checks each result in
// order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoa_source_localizer_tb;
  import tdoa_pkg::*;

  localparam int unsigned FB = DEF_FRACTION_BITS;
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd2;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [FIELD_W-1:0] rx[4];
    logic [FIELD_W-1:0] ref_rng;
  } ranges_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [STAT_W-1:0]       status;
  } fix_t;

  class fix_scoreboard;
    logic [FIELD_W-1:0] half_side;
    logic [FIELD_W-1:0] height;
    fix_t pending_fixes[$];
    int errors;

    function new();
      half_side = FIELD_W'(RESET_UNITS << FB);
      height = FIELD_W'(RESET_UNITS << FB);
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [FIELD_W-1:0] val);
      if (idx == CFG_HALF_SIDE) half_side = val;
      else if (idx == CFG_HEIGHT) height = val;
    endfunction

    function logic [POS_W-1:0] round_div(wide_t num, bit den_neg, wide_t den);
      wide_t mag, q, rm;
      bit neg;
      neg = (num < 0) != den_neg;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      rm = mag % den;
      if (rm >= den - rm) q = q + 1;
      if (neg) begin
        if (q > 128'sh8000_0000) q = 128'sh8000_0000;
        return POS_W'(-q);
      end
      if (q > 128'sh7FFF_FFFF) q = 128'sh7FFF_FFFF;
      return POS_W'(q);
    endfunction

    function fix_t solve_position(ranges_t r);
      wide_t d[4], sq[4];
      wide_t e, f, t, g, qe, qf, qg, sum, s, h, kk, az, gmag;
      fix_t p;
      s = $signed({108'd0, half_side});
      h = $signed({108'd0, height});
      for (int i = 0; i < 4; i++) begin
        d[i] = $signed({108'd0, r.rx[i]}) - $signed({108'd0, r.ref_rng});
        sq[i] = d[i] * d[i];
      end
      e = d[0] - d[1] - d[2] + d[3];
      f = d[0] + d[1] - d[2] - d[3];
      t = d[0] + d[1] + d[2] + d[3];
      g = d[0] - d[1] + d[2] - d[3];
      qe = sq[0] - sq[1] - sq[2] + sq[3];
      qf = sq[0] + sq[1] - sq[2] - sq[3];
      qg = sq[0] - sq[1] + sq[2] - sq[3];
      sum = sq[0] + sq[1] + sq[2] + sq[3];
      p.x = '0;
      p.y = '0;
      p.z = '0;
      if (sum == 0) begin
        p.status = STAT_ZERO_ENERGY;
        return p;
      end
      if (g == 0 || s == 0 || h == 0) begin
        p.status = STAT_SINGULAR;
        return p;
      end
      kk = 2 * s * s + h * h;
      az = 4 * kk - sum;
      gmag = (g < 0) ? -g : g;
      p.x = round_div(e * qg - g * qe, g < 0, 8 * s * gmag);
      p.y = round_div(f * qg - g * qf, g < 0, 8 * s * gmag);
      p.z = round_div(az * g + t * qg, g < 0, 8 * h * gmag);
      p.status = STAT_OK;
      return p;
    endfunction

    function void note_request(ranges_t r);
      pending_fixes.push_back(solve_position(r));
    endfunction

    function void check_fix(fix_t got);
      fix_t exp_fix;
      if (pending_fixes.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d status=%0d",
               got.x, got.y, got.z, got.status);
        errors++;
        return;
      end
      exp_fix = pending_fixes.pop_front();
      if (got.x !== exp_fix.x) begin
        $error("pos_x expected %0d actual %0d", exp_fix.x, got.x);
        errors++;
      end
      if (got.y !== exp_fix.y) begin
        $error("pos_y expected %0d actual %0d", exp_fix.y, got.y);
        errors++;
      end
      if (got.z !== exp_fix.z) begin
        $error("pos_z expected %0d actual %0d", exp_fix.z, got.z);
        errors++;
      end
      if (got.status !== exp_fix.status) begin
        $error("status expected %0d actual %0d", exp_fix.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   sink_burst;
  fix_scoreboard sb;

  tdoa_in_if  rng_if();
  tdoa_cfg_if cfg_if();
  tdoa_out_if pos_if();

  tdoa_source_localizer #(.FRACTION_BITS(FB)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rng_i  (rng_if),
    .cfg_i  (cfg_if),
    .pos_o  (pos_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("tdoa_source_localizer regression: fail");
    $finish;
  end

  task automatic send_ranges(ranges_t r, int unsigned gap);
    if (gap > 0) begin
      rng_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rng_if.valid     <= 1'b1;
    rng_if.range_rx0 <= r.rx[0];
    rng_if.range_rx1 <= r.rx[1];
    rng_if.range_rx2 <= r.rx[2];
    rng_if.range_rx3 <= r.rx[3];
    rng_if.range_ref <= r.ref_rng;
    do @(posedge clk_i); while (!rng_if.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    rng_if.valid <= 1'b0;
    while (sb.pending_fixes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_geometry(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] h);
    logic [CIDX_W-1:0] idx[2];
    logic [FIELD_W-1:0] val[2];
    idx[0] = CFG_HALF_SIDE;
    idx[1] = CFG_HEIGHT;
    val[0] = s;
    val[1] = h;
    for (int i = 0; i < 2; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic ranges_t make_ranges(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                          logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d,
                                          logic [FIELD_W-1:0] rr);
    ranges_t r;
    r.rx[0] = a;
    r.rx[1] = b;
    r.rx[2] = c;
    r.rx[3] = d;
    r.ref_rng = rr;
    return r;
  endfunction

  function automatic ranges_t random_ranges();
    ranges_t r;
    int unsigned mode;
    int signed spread;
    mode = $urandom_range(0, 3);
    r.ref_rng = FIELD_W'($urandom);
    spread = (mode == 0) ? 64 : (mode == 1) ? 4096 : 262144;
    for (int i = 0; i < 4; i++) begin
      if (mode == 3) r.rx[i] = FIELD_W'($urandom);
      else r.rx[i] = r.ref_rng + FIELD_W'($urandom_range(0, 2 * spread) - spread);
    end
    if ($urandom_range(0, 15) == 0) r.rx[3] = r.rx[0] - r.rx[1] + r.rx[2];
    return r;
  endfunction

  task automatic random_batch(int unsigned n);
    int unsigned gap;
    bit burst;
    burst = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 31) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      send_ranges(random_ranges(), gap);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    rng_if.valid <= 1'b0;
    rng_if.range_rx0 <= '0;
    rng_if.range_rx1 <= '0;
    rng_if.range_rx2 <= '0;
    rng_if.range_rx3 <= '0;
    rng_if.range_ref <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_ranges(make_ranges(0, 0, 0, 0, 0), 0);
    send_ranges(make_ranges(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX), 0);
    send_ranges(make_ranges(300, 300, 300, 300, 100), 1);
    send_ranges(make_ranges(FIELD_MAX, 0, FIELD_MAX, 0, 0), 0);
    send_ranges(make_ranges(FIELD_MAX, FIELD_MAX, 0, FIELD_MAX, 0), 2);
    send_ranges(make_ranges(0, 0, 0, FIELD_MAX, FIELD_MAX), 0);
    send_ranges(make_ranges(3000, 2800, 2900, 3100, 2000), 0);
    send_ranges(make_ranges(0, 1, 0, 0, 0), 3);
    send_ranges(make_ranges(1, 0, 0, 0, 0), 0);
    send_ranges(make_ranges(FIELD_MAX, 0, 0, 0, FIELD_MAX), 0);
    random_batch(90);
    drain();

    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SPARE;
    cfg_if.data  <= FIELD_MAX;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(CFG_SPARE, FIELD_MAX);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    write_geometry(FIELD_MAX, FIELD_MAX);
    send_ranges(make_ranges(FIELD_MAX, 0, FIELD_MAX, 0, 0), 0);
    random_batch(100);
    drain();

    write_geometry(0, 2560);
    send_ranges(make_ranges(3000, 2800, 2900, 3100, 2000), 0);
    random_batch(30);
    drain();

    write_geometry(2560, 0);
    send_ranges(make_ranges(3000, 2800, 2900, 3100, 2000), 0);
    random_batch(30);
    drain();

    write_geometry(1, 1);
    send_ranges(make_ranges(FIELD_MAX, 0, FIELD_MAX, 0, 0), 0);
    random_batch(100);
    drain();

    for (int k = 0; k < 5; k++) begin
      write_geometry(FIELD_W'($urandom), FIELD_W'($urandom));
      random_batch(50);
      drain();
    end

    write_geometry(FIELD_W'(RESET_UNITS << FB), FIELD_W'(RESET_UNITS << FB));
    random_batch(200);
    drain();

    if (sb.errors == 0) begin
      $display("tdoa_source_localizer regression: pass");
    end else begin
      $display("tdoa_source_localizer regression: fail");
    end
    $finish;
  end

  initial begin
    fix_t got;
    int unsigned gap;
    pos_if.ready <= 1'b0;
    sink_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_burst = ~sink_burst;
      gap = sink_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        pos_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pos_if.ready <= 1'b1;
      do @(posedge clk_i); while (!pos_if.valid);
      got.x = pos_if.pos_x;
      got.y = pos_if.pos_y;
      got.z = pos_if.pos_z;
      got.status = pos_if.status;
      sb.check_fix(got);
    end
  end

endmodule

`default_nettype wire
